[hdl/xue_pkg.sv]
// Shared types and byte-generation functions for the XML-escaping UTF-8 encoder.
package xue_pkg;

    // How one code unit is carried out by the back end
    typedef enum logic [2:0] {
        KIND_ONE   = 3'd0,
        KIND_TWO   = 3'd1,
        KIND_THREE = 3'd2,
        KIND_LT    = 3'd3,
        KIND_GT    = 3'd4,
        KIND_AMP   = 3'd5,
        KIND_APOS  = 3'd6,
        KIND_QUOT  = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] unit;
    } entry_t;

    localparam logic [15:0] CHAR_LT   = 16'h003c;
    localparam logic [15:0] CHAR_GT   = 16'h003e;
    localparam logic [15:0] CHAR_AMP  = 16'h0026;
    localparam logic [15:0] CHAR_APOS = 16'h0027;
    localparam logic [15:0] CHAR_QUOT = 16'h0022;

    // Entity text, left aligned, zero padded to six bytes
    localparam logic [5:0][7:0] TEXT_LT   = {"&lt;", 16'h0000};
    localparam logic [5:0][7:0] TEXT_GT   = {"&gt;", 16'h0000};
    localparam logic [5:0][7:0] TEXT_AMP  = {"&amp;", 8'h00};
    localparam logic [5:0][7:0] TEXT_APOS = "&apos;";
    localparam logic [5:0][7:0] TEXT_QUOT = "&quot;";

    // Classify one code unit
    function automatic kind_t xue_classify(logic [15:0] cu, logic esc);
        kind_t k;
        if (esc && cu == CHAR_LT)        k = KIND_LT;
        else if (esc && cu == CHAR_GT)   k = KIND_GT;
        else if (esc && cu == CHAR_AMP)  k = KIND_AMP;
        else if (esc && cu == CHAR_APOS) k = KIND_APOS;
        else if (esc && cu == CHAR_QUOT) k = KIND_QUOT;
        else if (cu[15:7] == 9'd0)       k = KIND_ONE;
        else if (cu[15:11] == 5'd0)      k = KIND_TWO;
        else                             k = KIND_THREE;
        return k;
    endfunction

    // Number of bytes an entry produces
    function automatic logic [2:0] xue_length(kind_t k);
        logic [2:0] n;
        unique case (k)
            KIND_ONE:                n = 3'd1;
            KIND_TWO:                n = 3'd2;
            KIND_THREE:              n = 3'd3;
            KIND_LT, KIND_GT:        n = 3'd4;
            KIND_AMP:                n = 3'd5;
            KIND_APOS, KIND_QUOT:    n = 3'd6;
            default:                 n = 3'd1;
        endcase
        return n;
    endfunction

    // Byte number idx of an entry's output
    function automatic logic [7:0] xue_byte(entry_t e, logic [2:0] idx);
        logic [7:0]      b;
        logic [5:0][7:0] txt;
        logic [2:0]      pos;
        txt = TEXT_LT;
        pos = 3'd5 - idx;
        b   = 8'h00;
        unique case (e.kind)
            KIND_ONE:
                b = {1'b0, e.unit[6:0]};
            KIND_TWO:
                b = (idx == 3'd0) ? {3'b110, e.unit[10:6]} : {2'b10, e.unit[5:0]};
            KIND_THREE:
                if (idx == 3'd0)      b = {4'b1110, e.unit[15:12]};
                else if (idx == 3'd1) b = {2'b10, e.unit[11:6]};
                else                  b = {2'b10, e.unit[5:0]};
            default:
            begin
                case (e.kind)
                    KIND_GT:   txt = TEXT_GT;
                    KIND_AMP:  txt = TEXT_AMP;
                    KIND_APOS: txt = TEXT_APOS;
                    KIND_QUOT: txt = TEXT_QUOT;
                    default:   txt = TEXT_LT;
                endcase
                b = txt[pos];
            end
        endcase
        return b;
    endfunction

endpackage

[hdl/xue_front.sv]
// Front end: accepts code units, holds the escape register, classifies each item.
module xue_front
    import xue_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    output logic        push_valid,
    input  logic        push_ready,
    output entry_t      push_entry
);

    logic   escape_reg;
    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;

    // Take a new item when the stage is empty or its item moves on now
    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    // Hold the escape setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            escape_reg <= 1'b0;
        else if (cfg_we)
            escape_reg <= cfg_data;
    end

    // Advance the classification stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            entry_reg.kind <= xue_classify(code_unit, escape_reg);
            entry_reg.unit <= code_unit;
        end
    end

endmodule

[hdl/xue_queue.sv]
// Short queue of classified items between the front and back ends.
module xue_queue
    import xue_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   head_valid,
    input  logic   pop,
    output entry_t head_entry
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[hdl/xue_back.sv]
// Back end: steps through the bytes of the head item into the output register.
module xue_back
    import xue_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       advance;
    logic       fire;
    logic       at_last;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = head_valid && advance;
    assign at_last   = idx_reg == (xue_length(head_entry.kind) - 3'd1);
    assign pop       = fire && at_last;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = head_valid;
        if (fire)
            idx_next = at_last ? 3'd0 : idx_reg + 3'd1;
    end

    // Hold byte index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the next byte of the item
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= xue_byte(head_entry, idx_reg);
            last_reg     <= at_last;
        end
    end

endmodule

[hdl/xml_escaping_utf8_encoder.sv]
// Top level of the XML-escaping UTF-8 encoder: front end, queue, back end.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------
//  input    | in_valid / in_ready   | code_unit[15:0]
//  output   | out_valid / out_ready | out_byte[7:0], last_byte
//  config   | cfg_we                | cfg_data (escape enable)
//
// An item gives as many output bytes as its kind calls for: 1 for ASCII, 2 or 3 for
// UTF-8 sequences, 4 to 6 for entities; the back end's byte sequencer sets this.
// An accepted item passes through the front stage, a queue slot and the output
// register, in that order, before its first byte is offered.
// Reset clears the escape enable, the queue and all valid flags.
// Input stalls only when the front stage holds an item and the queue is full;
// output stalls hold the output register.
module xml_escaping_utf8_encoder
    import xue_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    xue_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_unit  (code_unit),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    xue_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    xue_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    // An accepted item sits in the front stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> push_valid)
        else $error("accepted item lost in front stage");

    // A classified item waiting on a full queue stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && $stable(push_entry)))
        else $error("front stage dropped or changed a stalled item");

    // The back end pops only an item that is present
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    // A popped item always produced a final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last_byte))
        else $error("item finished without a last byte");

endmodule

[tb/xml_escaping_utf8_encoder_tb.sv]
// Self-checking testbench for the XML-escaping UTF-8 encoder: directed, random and stall tests.
module xml_escaping_utf8_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xue_pkg::*;

    typedef struct {
        logic [7:0] octet;
        logic       is_last;
    } out_char_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] code_unit;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_byte;

    // Bytes still owed by the encoder, oldest first
    out_char_t expected_bytes[$];
    logic      escape_shadow;
    int        mismatch_count;
    bit        send_steady;
    bit        sink_steady;
    int        hold_cycles_req;

    xml_escaping_utf8_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_unit (code_unit),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #(2_000_000);
        $display("xml_escaping_utf8_encoder_tb: done, errors");
        $finish;
    end

    function automatic void push_byte(input logic [7:0] b, input logic is_last);
        out_char_t c;
        c.octet   = b;
        c.is_last = is_last;
        expected_bytes.push_back(c);
    endfunction

    // Queue the bytes one code unit should produce under the current escape setting
    function automatic void push_encoded(input logic [15:0] cu);
        string ent;
        ent = "";
        if (escape_shadow)
        begin
            case (cu)
                CHAR_LT:   ent = "&lt;";
                CHAR_GT:   ent = "&gt;";
                CHAR_AMP:  ent = "&amp;";
                CHAR_APOS: ent = "&apos;";
                CHAR_QUOT: ent = "&quot;";
                default:   ent = "";
            endcase
        end
        if (ent.len() != 0)
        begin
            for (int i = 0; i < ent.len(); i++)
                push_byte(ent[i], i == ent.len() - 1);
        end
        else if (cu < 16'h0080)
        begin
            push_byte(cu[7:0], 1'b1);
        end
        else if (cu < 16'h0800)
        begin
            push_byte({3'b110, cu[10:6]}, 1'b0);
            push_byte({2'b10, cu[5:0]}, 1'b1);
        end
        else
        begin
            push_byte({4'b1110, cu[15:12]}, 1'b0);
            push_byte({2'b10, cu[11:6]}, 1'b0);
            push_byte({2'b10, cu[5:0]}, 1'b1);
        end
    endfunction

    // Pick a code unit, weighted toward the interesting ranges
    function automatic logic [15:0] random_text_unit();
        logic [15:0] cu;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 25)
        begin
            case ($urandom_range(4))
                0:       cu = CHAR_LT;
                1:       cu = CHAR_GT;
                2:       cu = CHAR_AMP;
                3:       cu = CHAR_APOS;
                default: cu = CHAR_QUOT;
            endcase
        end
        else if (sel < 50)
            cu = 16'($urandom_range(16'h007f));
        else if (sel < 68)
            cu = 16'($urandom_range(16'h07ff, 16'h0080));
        else if (sel < 80)
            cu = 16'($urandom_range(16'hdfff, 16'hd800));
        else
            cu = 16'($urandom_range(16'hffff));
        return cu;
    endfunction

    // Offer one item and hold it until accepted, with optional idle cycles first
    task automatic send_unit(input logic [15:0] cu);
        int gap;
        if (!send_steady && $urandom_range(99) < 19)
        begin
            gap = $urandom_range(3, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        code_unit <= cu;
        do
            @(posedge clk);
        while (!in_ready);
        push_encoded(cu);
    endtask

    // Drop valid and wait until every owed byte has come out
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the escape enable while the encoder is idle
    task automatic set_escape(input logic en);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= en;
        @(posedge clk);
        cfg_we   <= 1'b0;
        escape_shadow = en;
    endtask

    task automatic test_plain_encoding;
        logic [15:0] units[13];
        units = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff,
                  16'hd800, 16'hdfff, 16'h5555, 16'haaaa, CHAR_LT, CHAR_AMP, CHAR_QUOT};
        foreach (units[i])
            send_unit(units[i]);
        drain();
    endtask

    task automatic test_entity_escape;
        logic [15:0] units[10];
        units = '{CHAR_LT, CHAR_GT, CHAR_AMP, CHAR_APOS, CHAR_QUOT,
                  16'h003d, 16'h013c, 16'h2226, 16'h0000, 16'hffff};
        set_escape(1'b1);
        foreach (units[i])
            send_unit(units[i]);
        drain();
    endtask

    // Random text in phases, toggling the escape enable between them
    task automatic test_random_text;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_escape(phase[0] ? 1'b0 : 1'b1);
            send_steady = (phase == 2);
            sink_steady = (phase == 2);
            for (int n = 0; n < 38; n++)
                send_unit(random_text_unit());
        end
        send_steady = 1'b0;
        sink_steady = 1'b0;
        drain();
    endtask

    // Hold the output off long enough for the input to back up
    task automatic test_output_stall;
        set_escape(1'b1);
        send_steady     = 1'b1;
        hold_cycles_req = 120;
        for (int n = 0; n < 20; n++)
            send_unit(random_text_unit());
        send_steady = 1'b0;
        drain();
    endtask

    // Receiver: random stalls, plus one long hold when requested
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req > 0)
            begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!sink_steady && $urandom_range(99) < 19)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each output byte with the oldest expected one
    always @(posedge clk)
    begin : check_output
        out_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected byte %02h last %0b", $realtime,
                             out_byte, last_byte);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.octet || last_byte !== want.is_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: byte exp %02h got %02h, last exp %0b got %0b",
                                 $realtime, want.octet, out_byte, want.is_last,
                                 last_byte);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 1'b0;
        in_valid        = 1'b0;
        code_unit       = 16'h0000;
        escape_shadow   = 1'b0;
        mismatch_count  = 0;
        send_steady     = 1'b0;
        sink_steady     = 1'b0;
        hold_cycles_req = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_encoding();
        test_entity_escape();
        test_random_text();
        test_output_stall();
        set_escape(1'b0);

        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("xml_escaping_utf8_encoder_tb: done, clean");
        else
            $display("xml_escaping_utf8_encoder_tb: done, errors");
        $finish;
    end

endmodule
